[rtl/sky_border_column_scan_core_defines.svh]
// Assertion macros for the sky border column scan RTL.
`ifndef SKY_BORDER_COLUMN_SCAN_CORE_DEFINES_SVH
`define SKY_BORDER_COLUMN_SCAN_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SBCS_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBCS_ASSERT(lbl, prop, msg) `SBCS_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)
`else
`define SBCS_ASSERT_CR(lbl, clk, rst_n, prop, msg)
`define SBCS_ASSERT(lbl, prop, msg)
`endif
`endif

[rtl/sbcs_pkg.sv]
// Constants and register codes of the sky border column scan.
package sbcs_pkg;

  localparam int GRAD_W    = 15;
  localparam int DIM_W     = 12;
  localparam int LIM_W     = 12;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int COL_OUT_W = 11;
  localparam int ACC_W     = 23;
  localparam int OUT_W     = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAD_THR   = 3'd0,
    CFG_WIDTH      = 3'd1,
    CFG_HEIGHT     = 3'd2,
    CFG_NO_SKY     = 3'd3,
    CFG_LOW_SKY    = 3'd4,
    CFG_JUMP_MEAN  = 3'd5,
    CFG_PARTIAL    = 3'd6
  } cfg_idx_e;

endpackage

[rtl/sbcs_col_store.sv]
// Per-column border memory with registered read and write-to-read forwarding.
module sbcs_col_store #(
  parameter int DEPTH = 2048,
  parameter int DW    = 12,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;
  logic [DW-1:0] byp_data_q;
  logic          byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // same entry written in the cycle it is read: the array returns the old word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

[rtl/sky_border_column_scan_core.sv]
// Top level of the sky border column scan: counters, column update, sums and verdict.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------------
//  in      | in_valid_i / in_ready_o    | gradient_i
//  out     | out_valid_o / out_ready_i  | column_o border_row_o last_o border_sum_o
//          |                            | jump_sum_o has_sky_o partial_sky_o
//  cfg     | cfg_we_i                   | cfg_idx_i cfg_wdata_i
//
//  One item per cycle sustained while in_ready_o stays high. The column memory read
//  sits in the accept cycle; the stage register then holds the item for update and
//  write-back and, on the last row, for the load into the output register.
//  in_ready_o drops only when a last-row item is waiting and the output register
//  is full and not being taken.
//  Reset clears counters, sums and config to defaults; the column memory is not
//  cleared, every entry is rewritten in row 0 of each frame.
module sky_border_column_scan_core
  import sbcs_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [GRAD_W-1:0]    gradient_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COL_OUT_W-1:0] column_o,
  output logic [COL_OUT_W-1:0] border_row_o,
  output logic                 last_o,
  output logic [OUT_W-1:0]     border_sum_o,
  output logic [OUT_W-1:0]     jump_sum_o,
  output logic                 has_sky_o,
  output logic                 partial_sky_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  `include "sky_border_column_scan_core_defines.svh"

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = LIM_W + WW;
  localparam int EW = RW + 1;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [RW-1:0] cand;
    logic [RW-1:0] hm1;
    logic          hit;
    logic          row_zero;
    logic          last_row;
    logic          last_col;
  } s1_t;

  // configuration
  logic [GRAD_W-1:0] grad_thr_q;
  logic [DIM_W-1:0]  frame_width_q, frame_height_q;
  logic [LIM_W-1:0]  no_sky_q, low_sky_q, jump_mean_q, partial_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_thr_q     <= GRAD_W'(80);
      frame_width_q  <= DIM_W'(640);
      frame_height_q <= DIM_W'(480);
      no_sky_q       <= LIM_W'(16);
      low_sky_q      <= LIM_W'(120);
      jump_mean_q    <= LIM_W'(20);
      partial_lim_q  <= LIM_W'(213);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRAD_THR:  grad_thr_q     <= cfg_wdata_i[GRAD_W-1:0];
        CFG_WIDTH:     frame_width_q  <= cfg_wdata_i[DIM_W-1:0];
        CFG_HEIGHT:    frame_height_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_NO_SKY:    no_sky_q       <= cfg_wdata_i[LIM_W-1:0];
        CFG_LOW_SKY:   low_sky_q      <= cfg_wdata_i[LIM_W-1:0];
        CFG_JUMP_MEAN: jump_mean_q    <= cfg_wdata_i[LIM_W-1:0];
        CFG_PARTIAL:   partial_lim_q  <= cfg_wdata_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [WW-1:0] w_eff;

  always_comb begin
    if (frame_width_q == '0) begin
      wm1 = '0;
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(frame_width_q - DIM_W'(1));
    end
    if (frame_height_q == '0) begin
      hm1 = '0;
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(frame_height_q - DIM_W'(1));
    end
  end

  assign w_eff = WW'(wm1) + WW'(1);

  // limit * width, refreshed every cycle; the user moves config only while idle, the block does not enforce it
  logic [PW-1:0] prod_no_q, prod_low_q, prod_jump_q;

  always_ff @(posedge clk_i) begin
    prod_no_q   <= PW'(no_sky_q) * PW'(w_eff);
    prod_low_q  <= PW'(low_sky_q) * PW'(w_eff);
    prod_jump_q <= PW'(jump_mean_q) * PW'(w_eff);
  end

  // handshake and pipeline control
  logic s1_valid_q, s1_go, s1_fire, in_acc, out_load;
  logic out_valid_q;
  s1_t  s1_q, s1_d;

  assign s1_go      = !s1_q.last_row || !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = s1_fire && s1_q.last_row;

  // accept stage: position in frame
  logic [CW-1:0] col_count_q;
  logic [RW-1:0] row_count_q;

  always_comb begin
    s1_d.col      = (col_count_q > wm1) ? wm1 : col_count_q;
    s1_d.cand     = (row_count_q >= hm1) ? hm1 : row_count_q;
    s1_d.hm1      = hm1;
    s1_d.hit      = gradient_i > grad_thr_q;
    s1_d.row_zero = row_count_q == '0;
    s1_d.last_row = row_count_q >= hm1;
    s1_d.last_col = s1_d.col == wm1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        if (s1_d.last_col) begin
          col_count_q <= '0;
          row_count_q <= s1_d.last_row ? '0 : row_count_q + RW'(1);
        end else begin
          col_count_q <= s1_d.col + CW'(1);
        end
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // column memory: entry is {found, border}
  logic [EW-1:0] ent_rd, ent_wr;

  sbcs_col_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (EW)
  ) u_col_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (s1_d.col),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_q.col),
    .wr_data_i (ent_wr),
    .rd_data_o (ent_rd)
  );

  logic [RW-1:0] b;

  always_comb begin
    if (s1_q.row_zero) begin
      ent_wr = {s1_q.hit, s1_q.hm1};
    end else if (!ent_rd[EW-1] && s1_q.hit) begin
      ent_wr = {1'b1, s1_q.cand};
    end else begin
      ent_wr = ent_rd;
    end
    b = ent_wr[RW-1:0];
  end

  // last-row sums
  logic [ACC_W-1:0] sum_q, jump_q, sum_nxt, jump_nxt;
  logic [RW-1:0]    prev_q, jump;
  logic [ACC_W:0]   sum_wide, jump_wide;
  logic             partial_q, partial_nxt, col0, verdict;

  always_comb begin
    col0      = s1_q.col == '0;
    jump      = (b >= prev_q) ? (b - prev_q) : (prev_q - b);
    sum_wide  = {1'b0, sum_q} + (ACC_W + 1)'(b);
    jump_wide = {1'b0, jump_q} + (ACC_W + 1)'(jump);
    if (col0) begin
      sum_nxt     = ACC_W'(b);
      jump_nxt    = '0;
      partial_nxt = 1'b0;
    end else begin
      sum_nxt     = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
      jump_nxt    = jump_wide[ACC_W] ? '1 : jump_wide[ACC_W-1:0];
      partial_nxt = partial_q || (32'(jump) > 32'(partial_lim_q));
    end
    verdict = !((32'(sum_nxt) < 32'(prod_no_q)) ||
                ((32'(jump_nxt) > 32'(prod_jump_q)) && (32'(sum_nxt) < 32'(prod_low_q))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      jump_q    <= '0;
      prev_q    <= '0;
      partial_q <= 1'b0;
    end else if (out_load) begin
      sum_q     <= sum_nxt;
      jump_q    <= jump_nxt;
      prev_q    <= b;
      partial_q <= partial_nxt;
    end
  end

  // output register
  logic [COL_OUT_W-1:0] out_col_q, out_border_q;
  logic [OUT_W-1:0]     out_sum_q, out_jump_q;
  logic                 out_last_q, out_has_sky_q, out_partial_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q     <= COL_OUT_W'(s1_q.col);
      out_border_q  <= COL_OUT_W'(b);
      out_last_q    <= s1_q.last_col;
      out_sum_q     <= sum_nxt[ACC_W-1] ? '1 : sum_nxt[OUT_W-1:0];
      out_jump_q    <= jump_nxt[ACC_W-1] ? '1 : jump_nxt[OUT_W-1:0];
      out_has_sky_q <= s1_q.last_col && verdict;
      out_partial_q <= partial_nxt;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign column_o      = out_col_q;
  assign border_row_o  = out_border_q;
  assign last_o        = out_last_q;
  assign border_sum_o  = out_sum_q;
  assign jump_sum_o    = out_jump_q;
  assign has_sky_o     = out_has_sky_q;
  assign partial_sky_o = out_partial_q;

  `SBCS_ASSERT(a_stall_cause, !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i, "input stalled without a blocked result")
  `SBCS_ASSERT(a_sky_on_last, out_valid_q && out_has_sky_q |-> out_last_q, "sky verdict outside the final column")
  `SBCS_ASSERT(a_partial_sticky, out_load && !col0 && partial_q |=> partial_q, "partial flag dropped inside a row")

endmodule

[bench/tb_sky_border_column_scan_core.sv]
// Self-checking testbench for the sky border column scan core.
module tb_sky_border_column_scan_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sbcs_pkg::*;

  localparam int MAX_COLS = 2048;
  localparam int MAX_ROWS = 2048;
  localparam int unsigned GRAD_MAX = (1 << GRAD_W) - 1;
  localparam int unsigned LIM_MAX = 2048;
  localparam int unsigned RANDOM_PIXELS = 630;
  // accept through stage register to output register, plus margin
  localparam int PIPE_SETTLE = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [COL_OUT_W-1:0] border_row;
    logic                 last;
    logic [OUT_W-1:0]     border_sum;
    logic [OUT_W-1:0]     jump_sum;
    logic                 has_sky;
    logic                 partial_sky;
  } border_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [GRAD_W-1:0]    gradient_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [COL_OUT_W-1:0] column_o;
  logic [COL_OUT_W-1:0] border_row_o;
  logic                 last_o;
  logic [OUT_W-1:0]     border_sum_o;
  logic [OUT_W-1:0]     jump_sum_o;
  logic                 has_sky_o;
  logic                 partial_sky_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  sky_border_column_scan_core #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .gradient_i   (gradient_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .column_o     (column_o),
    .border_row_o (border_row_o),
    .last_o       (last_o),
    .border_sum_o (border_sum_o),
    .jump_sum_o   (jump_sum_o),
    .has_sky_o    (has_sky_o),
    .partial_sky_o(partial_sky_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the registers, reset values
  logic [GRAD_W-1:0] thr_q       = 15'd80;
  logic [DIM_W-1:0]  width_q     = 12'd640;
  logic [DIM_W-1:0]  height_q    = 12'd480;
  logic [LIM_W-1:0]  no_sky_q    = 12'd16;
  logic [LIM_W-1:0]  low_sky_q   = 12'd120;
  logic [LIM_W-1:0]  jump_mean_q = 12'd20;
  logic [LIM_W-1:0]  partial_q   = 12'd213;

  // predictor copy of the scan state
  logic [COL_OUT_W-1:0] col_border [MAX_COLS];
  bit                   col_found  [MAX_COLS];
  logic [COL_OUT_W-1:0] row_pos      = '0;
  logic [COL_OUT_W-1:0] col_pos      = '0;
  logic [ACC_W-1:0]     border_acc   = '0;
  logic [ACC_W-1:0]     jump_acc     = '0;
  logic [COL_OUT_W-1:0] prev_border  = '0;
  bit                   partial_seen = 1'b0;

  logic [GRAD_W-1:0] pixel_fifo[$];
  border_result_t    border_results_due[$];

  int unsigned src_idle_pct = 33;
  int unsigned snk_idle_pct = 33;
  int unsigned pixels_queued = 0;
  int unsigned pixels_seen = 0;
  int unsigned borders_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned mismatches = 0;

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [ACC_W-1:0] sat_acc(input int unsigned v);
    return (v > (1 << ACC_W) - 1) ? '1 : v[ACC_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [ACC_W-1:0] v);
    return (v > (1 << OUT_W) - 1) ? '1 : v[OUT_W-1:0];
  endfunction

  // counters at or past their last position count as last and wrap
  function automatic void next_position(input int unsigned row, col, w, h,
                                        output int unsigned nrow, ncol);
    int unsigned c;
    c = (col < w) ? col : w - 1;
    if (c >= w - 1) begin
      ncol = 0;
      nrow = (row >= h - 1) ? 0 : row + 1;
    end else begin
      ncol = c + 1;
      nrow = row;
    end
  endfunction

  function automatic bit scan_pixel(input logic [GRAD_W-1:0] grad, output border_result_t res);
    int unsigned w, h, col, b, jump, nrow, ncol;
    longint unsigned wl;
    bit hit, last_row, last_col, no_sky, jumpy, low, got;
    w = eff_dim(width_q, MAX_COLS);
    h = eff_dim(height_q, MAX_ROWS);
    wl = w;
    hit = grad > thr_q;
    col = (col_pos < w) ? col_pos : w - 1;
    last_row = row_pos >= h - 1;
    last_col = col >= w - 1;
    res = '0;
    got = 1'b0;
    // a hit in row 0 still leaves the last row as the border
    if (row_pos == 0) begin
      col_found[col] = hit;
      col_border[col] = COL_OUT_W'(h - 1);
    end else if (!col_found[col] && hit) begin
      col_found[col] = 1'b1;
      col_border[col] = COL_OUT_W'((row_pos < h) ? row_pos : h - 1);
    end
    if (last_row) begin
      b = col_border[col];
      if (col == 0) begin
        border_acc = sat_acc(b);
        jump_acc = '0;
        partial_seen = 1'b0;
      end else begin
        jump = (b >= prev_border) ? b - prev_border : prev_border - b;
        border_acc = sat_acc(border_acc + b);
        jump_acc = sat_acc(jump_acc + jump);
        if (jump > partial_q) partial_seen = 1'b1;
      end
      prev_border = COL_OUT_W'(b);
      res.column = COL_OUT_W'(col);
      res.border_row = COL_OUT_W'(b);
      res.last = last_col;
      res.border_sum = sat_out(border_acc);
      res.jump_sum = sat_out(jump_acc);
      res.partial_sky = partial_seen;
      if (last_col) begin
        no_sky = border_acc < no_sky_q * wl;
        jumpy = jump_acc > jump_mean_q * wl;
        low = border_acc < low_sky_q * wl;
        res.has_sky = !(no_sky || (jumpy && low));
      end
      got = 1'b1;
    end
    next_position(row_pos, col, w, h, nrow, ncol);
    row_pos = COL_OUT_W'(nrow);
    col_pos = COL_OUT_W'(ncol);
    return got;
  endfunction

  function automatic int unsigned pixels_to_frame_end();
    int unsigned w, h, r, c, n;
    w = eff_dim(width_q, MAX_COLS);
    h = eff_dim(height_q, MAX_ROWS);
    r = row_pos;
    c = col_pos;
    n = 0;
    do begin
      next_position(r, c, w, h, r, c);
      n++;
    end while (r != 0 || c != 0);
    return n;
  endfunction

  function automatic logic [GRAD_W-1:0] pick_gradient(input int unsigned hit_pct);
    if ($urandom_range(9) == 0) return GRAD_W'($urandom);
    if (thr_q != GRAD_MAX && $urandom_range(99) < hit_pct)
      return GRAD_W'($urandom_range(GRAD_MAX, thr_q + 1));
    return GRAD_W'($urandom_range(thr_q, 0));
  endfunction

  task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                             input logic [OUT_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // driver: one item held until accepted, random gaps between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pixel_fifo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid_i <= 1'b1;
        gradient_i <= pixel_fifo.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor: predict on accepted pixels, compare accepted borders
  always @(posedge clk_i) begin : port_watch
    border_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pixels_seen++;
        if (scan_pixel(gradient_i, want)) border_results_due = {border_results_due, want};
      end
      if (out_valid_o && out_ready_i) begin
        if (border_results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual column %0d border %0d",
                   $time, column_o, border_row_o);
          mismatches++;
        end else begin
          want = border_results_due.pop_front();
          check_field("column", want.column, column_o);
          check_field("border_row", want.border_row, border_row_o);
          check_field("last", want.last, last_o);
          check_field("border_sum", want.border_sum, border_sum_o);
          check_field("jump_sum", want.jump_sum, jump_sum_o);
          check_field("has_sky", want.has_sky, has_sky_o);
          check_field("partial_sky", want.partial_sky, partial_sky_o);
          borders_checked++;
          if (want.last) frames_closed++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_GRAD_THR:  thr_q = data;
      CFG_WIDTH:     width_q = data[DIM_W-1:0];
      CFG_HEIGHT:    height_q = data[DIM_W-1:0];
      CFG_NO_SKY:    no_sky_q = data[LIM_W-1:0];
      CFG_LOW_SKY:   low_sky_q = data[LIM_W-1:0];
      CFG_JUMP_MEAN: jump_mean_q = data[LIM_W-1:0];
      CFG_PARTIAL:   partial_q = data[LIM_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sampled mid-cycle so the driver and monitor updates of the last edge have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_fifo.size() != 0 || in_valid_i || border_results_due.size() != 0);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic push_pixels(input int unsigned n, input int unsigned hit_pct);
    repeat (n) pixel_fifo = {pixel_fifo, pick_gradient(hit_pct)};
    pixels_queued += n;
  endtask

  // optionally stop feeding in the middle of the last row until all borders are out
  task automatic run_frame(input int unsigned hit_pct, input bit drain_mid);
    int unsigned n, half;
    n = pixels_to_frame_end();
    half = eff_dim(width_q, MAX_COLS) / 2;
    if (drain_mid && half > 0 && n > half) begin
      push_pixels(n - half, hit_pct);
      wait_drained();
      push_pixels(half, hit_pct);
    end else begin
      push_pixels(n, hit_pct);
    end
  endtask

  initial begin : stimulus
    logic [GRAD_W-1:0] frame_a [12] = '{15'h7FFF, 15'd80, 15'd81, 15'd0,
                                        15'd0, 15'd81, 15'd0, 15'h7FFF,
                                        15'd0, 15'd0, 15'd0, 15'd0};
    logic [GRAD_W-1:0] frame_b [3] = '{15'd0, 15'd1, 15'h7FFF};
    logic [GRAD_W-1:0] frame_d [4] = '{15'd0, 15'h2AAA, 15'h5555, 15'd0};
    int unsigned rand_base, hit_pct, h_val, lim_top, n;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults for threshold and limits, row 0 hits and a threshold tie
    write_reg(CFG_WIDTH, 15'd4);
    write_reg(CFG_HEIGHT, 15'd3);
    foreach (frame_a[i]) pixel_fifo = {pixel_fifo, frame_a[i]};
    wait_drained();

    // single-row frame: every border is row 0
    write_reg(CFG_GRAD_THR, 15'd0);
    write_reg(CFG_WIDTH, 15'd3);
    write_reg(CFG_HEIGHT, 15'd1);
    foreach (frame_b[i]) pixel_fifo = {pixel_fifo, frame_b[i]};
    wait_drained();

    // zero geometry saturates to a 1x1 frame
    write_reg(CFG_GRAD_THR, CFG_W'(GRAD_MAX));
    write_reg(CFG_WIDTH, 15'd0);
    write_reg(CFG_HEIGHT, 15'd0);
    write_reg(CFG_NO_SKY, 15'd0);
    write_reg(CFG_LOW_SKY, CFG_W'(LIM_MAX));
    write_reg(CFG_JUMP_MEAN, 15'd0);
    write_reg(CFG_PARTIAL, 15'd0);
    pixel_fifo = {pixel_fifo, 15'h7FFF};
    wait_drained();

    write_reg(CFG_GRAD_THR, 15'd0);
    write_reg(CFG_WIDTH, 15'd2);
    write_reg(CFG_HEIGHT, 15'd2);
    write_reg(CFG_NO_SKY, CFG_W'(LIM_MAX));
    write_reg(CFG_LOW_SKY, 15'd0);
    write_reg(CFG_JUMP_MEAN, CFG_W'(LIM_MAX));
    write_reg(CFG_PARTIAL, CFG_W'(LIM_MAX));
    write_reg(CFG_NONE, 15'h7FFF);
    foreach (frame_d[i]) pixel_fifo = {pixel_fifo, frame_d[i]};
    wait_drained();

    // widest and tallest frames, oversize values saturate; a shrink cuts them short
    write_reg(CFG_GRAD_THR, 15'd4000);
    write_reg(CFG_WIDTH, 15'h7FFF);
    write_reg(CFG_HEIGHT, 15'd1);
    push_pixels(200, 30);
    wait_drained();
    write_reg(CFG_WIDTH, 15'd200);
    run_frame(30, 1'b0);
    wait_drained();
    write_reg(CFG_GRAD_THR, CFG_W'(GRAD_MAX));
    write_reg(CFG_WIDTH, 15'd1);
    write_reg(CFG_HEIGHT, 15'h0FFF);
    write_reg(CFG_NO_SKY, 15'd0);
    push_pixels(200, 0);
    wait_drained();
    write_reg(CFG_HEIGHT, 15'd200);
    run_frame(0, 1'b0);
    wait_drained();

    rand_base = pixels_queued;
    while (pixels_queued - rand_base < RANDOM_PIXELS) begin
      n = pixels_queued - rand_base;
      src_idle_pct = (n >= 300 && n < 550) ? 0 : 33;
      snk_idle_pct = src_idle_pct;
      wait_drained();
      case ($urandom_range(7))
        0: write_reg(CFG_GRAD_THR, 15'd0);
        1: write_reg(CFG_GRAD_THR, CFG_W'(GRAD_MAX));
        default: write_reg(CFG_GRAD_THR, CFG_W'($urandom_range(GRAD_MAX)));
      endcase
      h_val = $urandom_range(0, 6);
      if ($urandom_range(7) == 0) write_reg(CFG_WIDTH, CFG_W'($urandom_range(13, 48)));
      else write_reg(CFG_WIDTH, CFG_W'($urandom_range(0, 12)));
      write_reg(CFG_HEIGHT, CFG_W'(h_val));
      // limits near the border scale so both verdict outcomes show up
      lim_top = ($urandom_range(5) == 0) ? LIM_MAX : 2 * h_val + 2;
      write_reg(CFG_NO_SKY, CFG_W'($urandom_range(0, lim_top)));
      write_reg(CFG_LOW_SKY, CFG_W'($urandom_range(0, lim_top)));
      write_reg(CFG_JUMP_MEAN, CFG_W'($urandom_range(0, lim_top)));
      write_reg(CFG_PARTIAL, CFG_W'($urandom_range(0, lim_top)));
      hit_pct = $urandom_range(0, 50);

      // geometry change mid-frame; width only shrinks so every column stays written
      if ($urandom_range(4) == 0) begin
        n = pixels_to_frame_end();
        if (n > 1) begin
          push_pixels($urandom_range(1, n - 1), hit_pct);
          wait_drained();
          write_reg(CFG_HEIGHT, CFG_W'($urandom_range(0, 6)));
          write_reg(CFG_WIDTH, CFG_W'($urandom_range(1, eff_dim(width_q, MAX_COLS))));
          run_frame(hit_pct, 1'b0);
        end
      end
      repeat ($urandom_range(1, 3)) run_frame(hit_pct, $urandom_range(3) == 0);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Scanned %0d pixels, checked %0d column borders over %0d frames.",
             pixels_seen, borders_checked, frames_closed);
    $display("Geometry from 1x1 to 2048 wide and 2048 tall, mid-frame changes, stalls.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("%0t: timeout, %0d results still due", $time, border_results_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/sbcs_pkg.sv
rtl/sbcs_col_store.sv
rtl/sky_border_column_scan_core.sv
bench/tb_sky_border_column_scan_core.sv
